// ===== hdl/ldf_pkg.sv =====
// shared types and constants for the length prefixed deframer
`default_nettype none

package ldf_pkg;

   localparam int unsigned HeaderBytes = 4;
   localparam int unsigned HdrCntW = $clog2(HeaderBytes);
   localparam logic [HdrCntW-1:0] HdrCntLast = HdrCntW'(HeaderBytes - 1);
   localparam logic [31:0] MaxFrameReset = 32'd32768;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] out_byte;
      kind_type   kind;
      logic       frame_end;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/ldf_channels.sv =====
// valid/ready channel interfaces for the deframer input and result streams
`default_nettype none

interface ldf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface ldf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] kind;
   logic       frame_end;

   modport source (output valid, output out_byte, output kind, output frame_end,
                   input ready);
   modport sink   (input valid, input out_byte, input kind, input frame_end,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/ldf_parser.sv =====
// header/payload parser state and per-word result logic
`default_nettype none

module ldf_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         in_byte,
   input  wire logic               csr_we,
   input  wire logic [31:0]        csr_wdata,
   output ldf_pkg::result_type     result
);
   import ldf_pkg::*;

   logic [31:0]        max_ff, max_in;
   logic [HdrCntW-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic [23:0]        accum_ff, accum_in;
   logic [31:0]        remain_ff, remain_in;
   logic               in_payload_ff, in_payload_in;
   logic               failed_ff, failed_in;
   logic [31:0]        length;

   assign length = {accum_ff, in_byte};

   always_comb begin
      max_in        = csr_we ? csr_wdata : max_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      accum_in      = accum_ff;
      remain_in     = remain_ff;
      in_payload_in = in_payload_ff;
      failed_in     = failed_ff;
      result        = '0;
      result.kind   = KIND_PAYLOAD;
      if (accept && !failed_ff) begin
         if (in_payload_ff) begin
            remain_in        = remain_ff - 32'd1;
            result.valid     = 1'b1;
            result.out_byte  = in_byte;
            result.frame_end = (remain_ff == 32'd1);
            if (remain_ff == 32'd1) begin
               in_payload_in = 1'b0;
            end
         end else begin
            accum_in = {accum_ff[15:0], in_byte};
            if (hdr_cnt_ff == HdrCntLast) begin
               hdr_cnt_in = '0;
               if (length > max_ff) begin
                  failed_in    = 1'b1;
                  result.valid = 1'b1;
                  result.kind  = KIND_ERROR;
               end else if (length == 32'd0) begin
                  result.valid     = 1'b1;
                  result.kind      = KIND_EMPTY;
                  result.frame_end = 1'b1;
               end else begin
                  remain_in     = length;
                  in_payload_in = 1'b1;
               end
            end else begin
               hdr_cnt_in = hdr_cnt_ff + HdrCntW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff        <= MaxFrameReset;
         hdr_cnt_ff    <= '0;
         accum_ff      <= '0;
         remain_ff     <= '0;
         in_payload_ff <= 1'b0;
         failed_ff     <= 1'b0;
      end else begin
         max_ff        <= max_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         accum_ff      <= accum_in;
         remain_ff     <= remain_in;
         in_payload_ff <= in_payload_in;
         failed_ff     <= failed_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ldf_out_reg.sv =====
// result register driving the response channel
`default_nettype none

module ldf_out_reg (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           load,
   input  wire ldf_pkg::result_type result,
   output logic                can_load,
   ldf_rsp_if.source           rsp_ch
);
   import ldf_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   kind_type   kind_ff, kind_in;
   logic       end_ff, end_in;

   // a new word may enter while the held result leaves in the same cycle
   assign can_load = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      kind_in  = kind_ff;
      end_in   = end_ff;
      if (load) begin
         valid_in = result.valid;
         byte_in  = result.out_byte;
         kind_in  = result.kind;
         end_in   = result.frame_end;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      kind_ff <= kind_in;
      end_ff  <= end_in;
   end

   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.out_byte  = byte_ff;
   assign rsp_ch.kind      = kind_ff;
   assign rsp_ch.frame_end = end_ff;

endmodule

`default_nettype wire

// ===== hdl/length_prefixed_deframer.sv =====
// length prefixed deframer: 4-byte big-endian header, then payload words
// latency: a result is valid on the cycle after its input word is accepted
// throughput: one input word per cycle while results are taken, set by the single result register
// ready drops only while a held result is not taken
// reset (synchronous): parser state cleared, maximum length back to 32768
`default_nettype none

module length_prefixed_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   ldf_req_if.sink          req_ch,
   ldf_rsp_if.source        rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata
);
   import ldf_pkg::*;

   result_type result;
   logic       can_load;
   logic       accept;

   assign req_ch.ready = can_load;
   assign accept       = req_ch.valid && can_load;

   ldf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_ch.in_byte),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   ldf_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .result   (result),
      .can_load (can_load),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire
